@@ sv/iiht_pkg.sv @@
// iiht_pkg: shared types and constants for the identifier intern hash table
// no dependencies
`default_nettype none
package iiht_pkg;
    localparam int BUCKETS    = 256;
    localparam int MAX_LENGTH = 32;
    localparam int SLOT_W     = $clog2(BUCKETS);
    localparam int CHAR_W     = $clog2(MAX_LENGTH);
    localparam int LEN_W      = $clog2(MAX_LENGTH + 2);
    localparam int QDEPTH     = 2;
    localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_LIMIT    = 2'd1,
        ST_TOO_LONG = 2'd2
    } status_t;

    // one finished spelling passed from front to back
    typedef struct packed {
        logic [63:0]      hash;
        logic [LEN_W-1:0] len;
        logic             buf_sel;
    } job_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_READ,
        BK_CHECK,
        BK_CMP,
        BK_COPY,
        BK_DONE
    } bk_state_t;

    function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
        logic [63:0] x;
        x = h ^ {56'd0, b};
        return x + (x << 1) + (x << 4) + (x << 5) + (x << 7) + (x << 8) + (x << 40);
    endfunction
endpackage
`default_nettype wire

@@ sv/identifier_intern_hash_table.sv @@
// identifier_intern_hash_table: top level, front/queue/back and pending buffer
// depends on iiht_pkg, iiht_front, iiht_queue, iiht_back, iiht_ram
`default_nettype none
// Bytes are taken one per cycle while start is high and busy low; busy rises
// only when two finished spellings are already queued for the probe unit.
// Each end-marked byte yields one result with done high for one cycle; the
// receiver cannot hold results off. The probe reads the length store for
// each bucket and, on a length hit, compares the spelling character by
// character; an insert copies one character per cycle. The hit path
// through the single-read character ram sets the per-spelling time.
module identifier_intern_hash_table (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [7:0]  char_byte,
    input  wire logic        end_of_spelling,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_data,
    output logic             done,
    output logic [7:0]       slot_index,
    output logic             was_inserted,
    output logic [1:0]       status,
    output logic [63:0]      spelling_hash
);
    import iiht_pkg::*;

    logic [7:0]      limit_reg;
    logic            take, q_push, q_full, q_valid, q_pop, stall;
    job_t            q_job, q_head;
    logic            pb_we;
    logic [CHAR_W:0] pb_waddr, pb_raddr;
    logic [7:0]      pb_wdata, pb_rdata;

    assign cfg_ready = 1'b1;
    assign busy      = stall;
    assign take      = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= 8'd192;
        end
        else if (cfg_valid && cfg_ready)
        begin
            limit_reg <= cfg_data;
        end
    end

    iiht_front u_front (
        .clk(clk), .rst_n(rst_n), .take(take), .char_byte(char_byte),
        .end_of_spelling(end_of_spelling), .q_full(q_full), .q_push(q_push),
        .q_job(q_job), .pb_we(pb_we), .pb_waddr(pb_waddr), .pb_wdata(pb_wdata),
        .stall(stall));

    // two pending spelling buffers, one per queue entry
    iiht_ram #(.WIDTH(8), .DEPTH(2 * MAX_LENGTH)) u_pend (
        .clk(clk), .we(pb_we), .waddr(pb_waddr), .wdata(pb_wdata),
        .raddr(pb_raddr), .rdata(pb_rdata));

    iiht_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(q_push), .push_job(q_job), .pop(q_pop),
        .full(q_full), .not_empty(q_valid), .head(q_head));

    iiht_back u_back (
        .clk(clk), .rst_n(rst_n), .entry_limit(limit_reg), .q_valid(q_valid),
        .q_head(q_head), .q_pop(q_pop), .pb_raddr(pb_raddr), .pb_rdata(pb_rdata),
        .done(done), .slot_index(slot_index), .was_inserted(was_inserted),
        .status(status), .spelling_hash(spelling_hash));

    a_take_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> !busy)
        else $error("request taken while busy");
    a_busy_full: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> q_full)
        else $error("busy without full queue");
    a_cfg_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(cfg_valid && cfg_ready) |=> limit_reg == $past(limit_reg))
        else $error("limit changed without write");
endmodule
`default_nettype wire

@@ sv/iiht_ram.sv @@
// iiht_ram: generic single-port-write, one-port-read ram with registered read
// no dependencies
`default_nettype none
module iiht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

@@ sv/iiht_front.sv @@
// iiht_front: byte intake, fnv-1a hashing and spelling buffer writes
// depends on iiht_pkg
`default_nettype none
module iiht_front (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        take,
    input  wire logic [7:0]                  char_byte,
    input  wire logic                        end_of_spelling,
    input  wire logic                        q_full,
    output logic                             q_push,
    output iiht_pkg::job_t                   q_job,
    output logic                             pb_we,
    output logic [iiht_pkg::CHAR_W:0]        pb_waddr,
    output logic [7:0]                       pb_wdata,
    output logic                             stall
);
    import iiht_pkg::*;

    logic [63:0]      hash_reg, hash_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic             sel_reg;
    logic [63:0]      h_new;
    logic [LEN_W-1:0] l_new;

    assign stall = q_full;
    assign h_new = fnv_step(hash_reg, char_byte);
    assign l_new = (len_reg <= LEN_W'(MAX_LENGTH)) ? len_reg + 1'b1 : len_reg;

    assign pb_we    = take && (len_reg < LEN_W'(MAX_LENGTH));
    assign pb_waddr = {sel_reg, len_reg[CHAR_W-1:0]};
    assign pb_wdata = char_byte;

    assign q_push      = take && end_of_spelling;
    assign q_job.hash  = h_new;
    assign q_job.len   = l_new;
    assign q_job.buf_sel = sel_reg;

    always_comb
    begin
        hash_next = hash_reg;
        len_next  = len_reg;
        if (take)
        begin
            hash_next = end_of_spelling ? FNV_BASIS : h_new;
            len_next  = end_of_spelling ? '0 : l_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg <= FNV_BASIS;
            len_reg  <= '0;
            sel_reg  <= 1'b0;
        end
        else
        begin
            hash_reg <= hash_next;
            len_reg  <= len_next;
            if (q_push)
            begin
                sel_reg <= ~sel_reg;
            end
        end
    end

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_W'(MAX_LENGTH + 1))
        else $error("length counter overran");
    a_reset_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |=> (len_reg == '0 && hash_reg == FNV_BASIS))
        else $error("front state not cleared after end");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("push into full queue");
endmodule
`default_nettype wire

@@ sv/iiht_queue.sv @@
// iiht_queue: two-entry request queue between front and back
// depends on iiht_pkg
`default_nettype none
module iiht_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire iiht_pkg::job_t push_job,
    input  wire logic           pop,
    output logic                full,
    output logic                not_empty,
    output iiht_pkg::job_t      head
);
    import iiht_pkg::*;

    job_t       q_reg [QDEPTH];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign full      = (cnt_reg == 2'(QDEPTH));
    assign not_empty = (cnt_reg != 2'd0);
    assign head      = q_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wp_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (pop)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("queue pop while empty");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 2'(QDEPTH))
        else $error("queue count overran");
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("queue push while full");
endmodule
`default_nettype wire

@@ sv/iiht_back.sv @@
// iiht_back: linear probe, compare and insert against the slot table
// depends on iiht_pkg and iiht_ram
`default_nettype none
module iiht_back (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic [7:0]             entry_limit,
    input  wire logic                   q_valid,
    input  wire iiht_pkg::job_t         q_head,
    output logic                        q_pop,
    output logic [iiht_pkg::CHAR_W:0]   pb_raddr,
    input  wire logic [7:0]             pb_rdata,
    output logic                        done,
    output logic [7:0]                  slot_index,
    output logic                        was_inserted,
    output logic [1:0]                  status,
    output logic [63:0]                 spelling_hash
);
    import iiht_pkg::*;

    localparam int CW = SLOT_W + CHAR_W;

    bk_state_t         st_reg, st_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [SLOT_W:0]   probes_reg, probes_next;
    logic [CHAR_W:0]   idx_reg, idx_next;
    logic [SLOT_W:0]   count_reg, count_next;
    logic [BUCKETS-1:0] used_reg;
    logic              set_used;
    logic [7:0]        o_slot_next;
    logic              o_ins_next;
    status_t           o_st_next;
    logic              emit;

    // slot length store
    logic              len_we;
    logic [LEN_W-1:0]  len_rdata;
    // slot char store
    logic              ch_we;
    logic [CW-1:0]     ch_waddr, ch_raddr;
    logic [7:0]        ch_rdata;
    logic [CHAR_W-1:0] rd_idx;
    logic              copying_reg;
    logic [CHAR_W-1:0] wr_idx_reg;

    iiht_ram #(.WIDTH(LEN_W), .DEPTH(BUCKETS)) u_len (
        .clk(clk), .we(len_we), .waddr(slot_reg), .wdata(q_head.len),
        .raddr(slot_next), .rdata(len_rdata));

    iiht_ram #(.WIDTH(8), .DEPTH(BUCKETS * MAX_LENGTH)) u_chars (
        .clk(clk), .we(ch_we), .waddr(ch_waddr), .wdata(pb_rdata),
        .raddr(ch_raddr), .rdata(ch_rdata));

    assign rd_idx   = idx_reg[CHAR_W-1:0];
    assign ch_raddr = {slot_next, rd_idx};
    assign pb_raddr = {q_head.buf_sel, rd_idx};
    // copy writes land in the cycle after the pending-buffer read
    assign ch_we    = copying_reg;
    assign ch_waddr = {slot_reg, wr_idx_reg};

    always_comb
    begin
        st_next     = st_reg;
        slot_next   = slot_reg;
        probes_next = probes_reg;
        idx_next    = idx_reg;
        count_next  = count_reg;
        q_pop       = 1'b0;
        len_we      = 1'b0;
        set_used    = 1'b0;
        emit        = 1'b0;
        o_slot_next = '0;
        o_ins_next  = 1'b0;
        o_st_next   = ST_OK;
        unique case (st_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_head.len > LEN_W'(MAX_LENGTH))
                    begin
                        emit      = 1'b1;
                        o_st_next = ST_TOO_LONG;
                        q_pop     = 1'b1;
                    end
                    else
                    begin
                        slot_next   = q_head.hash[SLOT_W-1:0];
                        probes_next = '0;
                        idx_next    = '0;
                        st_next     = BK_CHECK;
                    end
                end
            end
            BK_READ:
            begin
                st_next = BK_CHECK;
            end
            BK_CHECK:
            begin
                if (!used_reg[slot_reg])
                begin
                    q_pop = 1'b1;
                    if ({1'b0, count_reg} >= {2'b0, entry_limit})
                    begin
                        emit      = 1'b1;
                        o_st_next = ST_LIMIT;
                        st_next   = BK_IDLE;
                    end
                    else
                    begin
                        q_pop      = 1'b0;
                        len_we     = 1'b1;
                        set_used   = 1'b1;
                        count_next = count_reg + 1'b1;
                        idx_next   = '0;
                        st_next    = (q_head.len == '0) ? BK_DONE : BK_COPY;
                    end
                end
                else if (len_rdata == q_head.len)
                begin
                    if (q_head.len == '0)
                    begin
                        emit        = 1'b1;
                        o_slot_next = 8'(slot_reg);
                        q_pop       = 1'b1;
                        st_next     = BK_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                        st_next  = BK_CMP;
                    end
                end
                else
                begin
                    st_next = BK_IDLE;
                end
                // used bucket, other length: next bucket, or ST_LIMIT when all probed
                if (used_reg[slot_reg] && len_rdata != q_head.len)
                begin
                    if (probes_reg == (SLOT_W+1)'(BUCKETS - 1))
                    begin
                        emit      = 1'b1;
                        o_st_next = ST_LIMIT;
                        q_pop     = 1'b1;
                        st_next   = BK_IDLE;
                    end
                    else
                    begin
                        slot_next   = slot_reg + 1'b1;
                        probes_next = probes_reg + 1'b1;
                        idx_next    = '0;
                        st_next     = BK_READ;
                    end
                end
            end
            BK_CMP:
            begin
                // ch_rdata and pb_rdata hold char idx_reg-1
                if (ch_rdata != pb_rdata)
                begin
                    if (probes_reg == (SLOT_W+1)'(BUCKETS - 1))
                    begin
                        emit      = 1'b1;
                        o_st_next = ST_LIMIT;
                        q_pop     = 1'b1;
                        st_next   = BK_IDLE;
                    end
                    else
                    begin
                        slot_next   = slot_reg + 1'b1;
                        probes_next = probes_reg + 1'b1;
                        idx_next    = '0;
                        st_next     = BK_READ;
                    end
                end
                else if ((LEN_W)'(idx_reg) == q_head.len)
                begin
                    emit        = 1'b1;
                    o_slot_next = 8'(slot_reg);
                    q_pop       = 1'b1;
                    st_next     = BK_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            BK_COPY:
            begin
                if ((LEN_W)'(idx_reg) + 1'b1 >= q_head.len)
                begin
                    st_next = BK_DONE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            BK_DONE:
            begin
                emit        = 1'b1;
                o_slot_next = 8'(slot_reg);
                o_ins_next  = 1'b1;
                q_pop       = 1'b1;
                st_next     = BK_IDLE;
            end
            default:
            begin
                st_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            slot_index    <= o_slot_next;
            was_inserted  <= o_ins_next;
            status        <= o_st_next;
            spelling_hash <= q_head.hash;
        end
        wr_idx_reg <= idx_reg[CHAR_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg      <= BK_IDLE;
            slot_reg    <= '0;
            probes_reg  <= '0;
            idx_reg     <= '0;
            count_reg   <= '0;
            used_reg    <= '0;
            done        <= 1'b0;
            copying_reg <= 1'b0;
        end
        else
        begin
            st_reg      <= st_next;
            slot_reg    <= slot_next;
            probes_reg  <= probes_next;
            idx_reg     <= idx_next;
            count_reg   <= count_next;
            done        <= emit;
            copying_reg <= (st_reg == BK_COPY);
            if (set_used)
            begin
                used_reg[slot_reg] <= 1'b1;
            end
        end
    end

    a_emit_pops: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> q_pop)
        else $error("result without retiring request");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (SLOT_W+1)'(BUCKETS))
        else $error("stored count overran");
    a_insert_sets_used: assert property (@(posedge clk) disable iff (!rst_n)
        set_used |=> used_reg[$past(slot_reg)])
        else $error("insert did not mark slot");
endmodule
`default_nettype wire

@@ tb/iiht_checker.sv @@
// iiht_checker: watches requests, config writes and results of the intern table
// predicts each result in its own table model and counts mismatches; uses iiht_pkg
`timescale 1ns / 100ps
module iiht_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic        busy,
    input  wire logic [7:0]  char_byte,
    input  wire logic        end_of_spelling,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [7:0]  cfg_data,
    input  wire logic        done,
    input  wire logic [7:0]  slot_index,
    input  wire logic        was_inserted,
    input  wire logic [1:0]  status,
    input  wire logic [63:0] spelling_hash,
    output int               fail_count,
    output int               pending_results
);
    import iiht_pkg::*;

    typedef struct packed {
        logic [7:0]  slot;
        logic        ins;
        status_t     st;
        logic [63:0] hash;
    } lookup_t;

    lookup_t     lookup_q[$];
    logic [7:0]  limit_reg;
    logic [63:0] hash_acc;
    logic [7:0]  word_chars[MAX_LENGTH];
    int          word_len;
    logic        tbl_used[BUCKETS];
    int          tbl_len[BUCKETS];
    logic [7:0]  tbl_chars[BUCKETS][MAX_LENGTH];
    int          tbl_count;

    function automatic logic [63:0] fnv_fold(input logic [63:0] h, input logic [7:0] b);
        logic [63:0] x;
        x = h ^ {56'd0, b};
        return x * 64'h0000_0100_0000_01b3;
    endfunction

    function automatic lookup_t intern_word(input logic [63:0] h, input int len);
        lookup_t r;
        int      s;
        logic    same;
        r.hash = h;
        r.slot = 8'd0;
        r.ins = 1'b0;
        r.st = ST_LIMIT;
        if (len > MAX_LENGTH)
        begin
            r.st = ST_TOO_LONG;
            return r;
        end
        s = int'(h[7:0]);
        for (int i = 0; i < BUCKETS; i++)
        begin
            if (!tbl_used[s])
            begin
                if (tbl_count >= int'(limit_reg))
                    return r;
                tbl_used[s] = 1'b1;
                tbl_len[s] = len;
                for (int k = 0; k < len; k++)
                    tbl_chars[s][k] = word_chars[k];
                tbl_count++;
                r.slot = s[7:0];
                r.ins = 1'b1;
                r.st = ST_OK;
                return r;
            end
            if (tbl_len[s] == len)
            begin
                same = 1'b1;
                for (int k = 0; k < len; k++)
                    if (tbl_chars[s][k] != word_chars[k])
                        same = 1'b0;
                if (same)
                begin
                    r.slot = s[7:0];
                    r.st = ST_OK;
                    return r;
                end
            end
            s = (s + 1) % BUCKETS;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        lookup_t e;
        if (!rst_n)
        begin
            lookup_q.delete();
            limit_reg <= 8'd192;
            hash_acc = FNV_BASIS;
            word_len = 0;
            tbl_count = 0;
            for (int i = 0; i < BUCKETS; i++)
                tbl_used[i] = 1'b0;
            fail_count <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                limit_reg <= cfg_data;
            if (done)
            begin
                if (lookup_q.size() == 0)
                begin
                    $error("result with no request waiting");
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = lookup_q.pop_front();
                    if (slot_index !== e.slot || was_inserted !== e.ins ||
                        status !== e.st || spelling_hash !== e.hash)
                    begin
                        if (slot_index !== e.slot)
                            $error("slot_index expected %0d actual %0d", e.slot, slot_index);
                        if (was_inserted !== e.ins)
                            $error("was_inserted expected %0d actual %0d", e.ins, was_inserted);
                        if (status !== e.st)
                            $error("status expected %0d actual %0d", e.st, status);
                        if (spelling_hash !== e.hash)
                            $error("spelling_hash expected %h actual %h", e.hash, spelling_hash);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (start && !busy)
            begin
                hash_acc = fnv_fold(hash_acc, char_byte);
                if (word_len < MAX_LENGTH)
                    word_chars[word_len] = char_byte;
                if (word_len <= MAX_LENGTH)
                    word_len++;
                if (end_of_spelling)
                begin
                    lookup_q.push_back(intern_word(hash_acc, word_len));
                    hash_acc = FNV_BASIS;
                    word_len = 0;
                end
            end
        end
        pending_results = lookup_q.size();
    end
endmodule

@@ tb/tb_identifier_intern_hash_table.sv @@
// tb_identifier_intern_hash_table: stimulus and verdict for the intern table
// depends on iiht_pkg, identifier_intern_hash_table and iiht_checker
`timescale 1ns / 100ps
module tb_identifier_intern_hash_table;
    import iiht_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [7:0]  char_byte;
    logic        end_of_spelling;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_data;
    logic        done;
    logic [7:0]  slot_index;
    logic        was_inserted;
    logic [1:0]  status;
    logic [63:0] spelling_hash;
    int          fail_count;
    int          pending_results;
    int          idle_cycles;
    int          burst_left;
    int          bytes_sent;
    logic [7:0]  vocab[16][40];
    int          vocab_len[16];

    identifier_intern_hash_table i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .char_byte(char_byte), .end_of_spelling(end_of_spelling),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .done(done), .slot_index(slot_index), .was_inserted(was_inserted),
        .status(status), .spelling_hash(spelling_hash)
    );

    iiht_checker i_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .char_byte(char_byte), .end_of_spelling(end_of_spelling),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .done(done), .slot_index(slot_index), .was_inserted(was_inserted),
        .status(status), .spelling_hash(spelling_hash),
        .fail_count(fail_count), .pending_results(pending_results)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // watchdog on cycles with no accepted request, config write or result
    always @(posedge clk)
    begin
        if (start && !busy || done || cfg_valid && cfg_ready)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 50000)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // one byte request; start stays high across back-to-back bytes
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        start <= 1'b1;
        char_byte <= b;
        end_of_spelling <= last;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        bytes_sent++;
        @(negedge clk);
    endtask

    // drop start between bursts of traffic
    task automatic stop_burst();
        start <= 1'b0;
        burst_left = 0;
    endtask

    task automatic send_word(input int len, input logic [7:0] seed_b, input logic rnd);
        for (int i = 0; i < len; i++)
            send_byte(rnd ? 8'($urandom) : 8'(seed_b + i), i == len - 1);
    endtask

    task automatic send_vocab(input int k);
        for (int i = 0; i < vocab_len[k]; i++)
            send_byte(vocab[k][i], i == vocab_len[k] - 1);
    endtask

    task automatic write_limit(input logic [7:0] v);
        stop_burst();
        while (pending_results != 0)
            @(negedge clk);
        repeat (300) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic new_vocab();
        for (int k = 0; k < 16; k++)
        begin
            vocab_len[k] = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 34)
                                                      : $urandom_range(1, 6);
            for (int i = 0; i < vocab_len[k]; i++)
                vocab[k][i] = 8'($urandom);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        char_byte = 8'd0;
        end_of_spelling = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = 8'd0;
        idle_cycles = 0;
        burst_left = 0;
        bytes_sent = 0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        // directed: extremes, repeat lookups, exactly max length, too long, then limits 1 and 255
        send_byte(8'h00, 1'b1);
        send_byte(8'hff, 1'b1);
        send_byte(8'h00, 1'b1);
        send_byte(8'hff, 1'b1);
        send_word(MAX_LENGTH, 8'h41, 1'b0);
        send_word(MAX_LENGTH, 8'h41, 1'b0);
        send_word(MAX_LENGTH + 1, 8'h30, 1'b0);
        write_limit(8'd1);
        send_byte(8'h55, 1'b1);
        send_byte(8'h00, 1'b1);
        write_limit(8'd255);
        send_byte(8'haa, 1'b1);
        // random phases with different limits; mostly repeats from a vocabulary
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                1: write_limit(8'd255);
                2: write_limit(8'd8);
                3: write_limit(8'($urandom_range(1, 255)));
                4: write_limit(8'd1);
                5: write_limit(8'd192);
                default: ;
            endcase
            new_vocab();
            while (bytes_sent < 275 * (ph + 1))
            begin
                case ($urandom_range(0, 9))
                    0: send_word($urandom_range(1, 40), 8'd0, 1'b1);
                    1: send_word($urandom_range(1, 3), 8'd0, 1'b1);
                    default: send_vocab($urandom_range(0, 15));
                endcase
            end
        end
        stop_burst();
        while (pending_results != 0)
            @(negedge clk);
        repeat (300) @(negedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
